// File: design/movdec_pkg.sv
// ============================================================================
// movdec_pkg
// Shared types for the 16-bit MOV instruction decoder: form codes, decoder
// state and the decoded record.
// ============================================================================
package movdec_pkg;

   // Instruction form codes
   typedef enum logic [2:0] {
      FORM_RM_REG  = 3'd0,
      FORM_IMM_RM  = 3'd1,
      FORM_IMM_REG = 3'd2,
      FORM_MEM_ACC = 3'd3,
      FORM_ACC_MEM = 3'd4
   } form_type;

   localparam logic [1:0] MOD_REGISTER = 2'd3;
   localparam logic [1:0] MOD_DISP8    = 2'd1;
   localparam logic [1:0] MOD_DISP16   = 2'd2;
   localparam logic [1:0] MOD_NO_DISP  = 2'd0;
   localparam logic [2:0] RM_DIRECT    = 3'd6;
   localparam logic [2:0] LEN_SINGLE   = 3'd1;

   // Decoder state carried between bytes
   typedef struct packed {
      logic [2:0]  phase;
      form_type    form;
      logic [3:0]  opbits;
      logic [7:0]  modrm;
      logic [15:0] disp;
      logic [15:0] imm;
   } state_type;

   // One decoded instruction
   typedef struct packed {
      form_type    form;
      logic        word_size;
      logic        reg_is_dest;
      logic [1:0]  mode;
      logic [2:0]  reg_code;
      logic [2:0]  rm_code;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [2:0]  length;
      logic        bad_opcode;
   } rec_type;

endpackage

// File: design/movdec_step.sv
// ============================================================================
// movdec_step
// Next-state and record logic for one instruction byte.
// ============================================================================
module movdec_step (
   input  movdec_pkg::state_type state_cur,
   input  logic [7:0]            instr_byte,
   output movdec_pkg::state_type state_nxt,
   output logic                  emit,
   output movdec_pkg::rec_type   rec
);

   function automatic logic [1:0] disp_len(movdec_pkg::form_type f, logic [7:0] m);
      logic [1:0] n;
      n = 2'd0;
      if (f == movdec_pkg::FORM_MEM_ACC || f == movdec_pkg::FORM_ACC_MEM) begin
         n = 2'd2;
      end else if (f == movdec_pkg::FORM_RM_REG || f == movdec_pkg::FORM_IMM_RM) begin
         if (m[7:6] == movdec_pkg::MOD_DISP8) begin
            n = 2'd1;
         end else if (m[7:6] == movdec_pkg::MOD_DISP16) begin
            n = 2'd2;
         end else if (m[7:6] == movdec_pkg::MOD_NO_DISP && m[2:0] == movdec_pkg::RM_DIRECT) begin
            n = 2'd2;
         end
      end
      return n;
   endfunction

   function automatic logic word_bit(movdec_pkg::form_type f, logic [3:0] ob);
      return (f == movdec_pkg::FORM_IMM_REG) ? ob[3] : ob[0];
   endfunction

   logic       has_modrm;
   logic [1:0] dl_old;
   logic [1:0] dl_new;
   logic [1:0] il;
   logic [2:0] off;
   logic [2:0] k;
   logic [2:0] total;
   logic [2:0] phase_inc;

   always_comb begin
      state_nxt = state_cur;
      emit      = 1'b0;
      rec       = '0;
      has_modrm = (state_cur.form == movdec_pkg::FORM_RM_REG) ||
                  (state_cur.form == movdec_pkg::FORM_IMM_RM);
      dl_old    = disp_len(state_cur.form, state_cur.modrm);
      off       = 3'(state_cur.phase - 3'd1 - {2'b00, has_modrm});
      k         = 3'(off - {1'b0, dl_old});
      phase_inc = 3'(state_cur.phase + 3'd1);
      dl_new    = 2'd0;
      il        = 2'd0;
      total     = 3'd0;

      if (state_cur.phase == 3'd0) begin
         // opcode byte
         state_nxt.modrm  = '0;
         state_nxt.disp   = '0;
         state_nxt.imm    = '0;
         state_nxt.opbits = instr_byte[3:0];
         state_nxt.phase  = 3'd1;
         case (instr_byte) inside
            [8'h88:8'h8B]: state_nxt.form = movdec_pkg::FORM_RM_REG;
            [8'hC6:8'hC7]: state_nxt.form = movdec_pkg::FORM_IMM_RM;
            [8'hB0:8'hBF]: state_nxt.form = movdec_pkg::FORM_IMM_REG;
            [8'hA0:8'hA1]: state_nxt.form = movdec_pkg::FORM_MEM_ACC;
            [8'hA2:8'hA3]: state_nxt.form = movdec_pkg::FORM_ACC_MEM;
            default: begin
               state_nxt.form   = movdec_pkg::FORM_RM_REG;
               state_nxt.opbits = '0;
               state_nxt.phase  = 3'd0;
               emit             = 1'b1;
               rec.length       = movdec_pkg::LEN_SINGLE;
               rec.bad_opcode   = 1'b1;
            end
         endcase
      end else begin
         if (has_modrm && state_cur.phase == 3'd1) begin
            state_nxt.modrm = instr_byte;
         end else if (off < {1'b0, dl_old}) begin
            if (off == 3'd0) state_nxt.disp[7:0]  = instr_byte;
            else             state_nxt.disp[15:8] = instr_byte;
         end else begin
            if (k == 3'd0) state_nxt.imm[7:0]  = instr_byte;
            else           state_nxt.imm[15:8] = instr_byte;
         end

         dl_new = disp_len(state_cur.form, state_nxt.modrm);
         if (state_cur.form == movdec_pkg::FORM_IMM_RM ||
             state_cur.form == movdec_pkg::FORM_IMM_REG) begin
            il = {1'b0, 1'b1} + {1'b0, word_bit(state_cur.form, state_cur.opbits)};
         end
         total = 3'(3'd1 + {2'b00, has_modrm} + {1'b0, dl_new} + {1'b0, il});

         if (phase_inc >= total) begin
            emit              = 1'b1;
            state_nxt.phase   = 3'd0;
            rec.form          = state_cur.form;
            rec.word_size     = word_bit(state_cur.form, state_cur.opbits);
            rec.displacement  = state_nxt.disp;
            rec.immediate     = state_nxt.imm;
            rec.length        = total;
            case (state_cur.form)
               movdec_pkg::FORM_RM_REG: begin
                  rec.reg_is_dest = state_cur.opbits[1];
                  rec.mode        = state_nxt.modrm[7:6];
                  rec.reg_code    = state_nxt.modrm[5:3];
                  rec.rm_code     = state_nxt.modrm[2:0];
               end
               movdec_pkg::FORM_IMM_RM: begin
                  rec.mode    = state_nxt.modrm[7:6];
                  rec.rm_code = state_nxt.modrm[2:0];
               end
               movdec_pkg::FORM_IMM_REG: begin
                  rec.reg_is_dest = 1'b1;
                  rec.mode        = movdec_pkg::MOD_REGISTER;
                  rec.reg_code    = state_cur.opbits[2:0];
               end
               movdec_pkg::FORM_MEM_ACC: begin
                  rec.reg_is_dest = 1'b1;
                  rec.rm_code     = movdec_pkg::RM_DIRECT;
               end
               movdec_pkg::FORM_ACC_MEM: begin
                  rec.rm_code = movdec_pkg::RM_DIRECT;
               end
               default: begin
                  rec.rm_code = '0;
               end
            endcase
         end else begin
            state_nxt.phase = phase_inc;
         end
      end
   end

endmodule

// File: design/mov_instruction_decoder.sv
// ============================================================================
// mov_instruction_decoder
// Byte-stream decoder for the five 16-bit x86 MOV forms.
// ============================================================================
//  - req channel: one instruction byte per item (req_instr_byte); the first
//    byte of each instruction is its opcode. Accepted when req_valid is high
//    and req_stall is low.
//  - rsp channel: one record per completed instruction, or one error record
//    (rsp_bad_opcode, length 1) for a first byte that is not a MOV opcode.
//    Bytes that do not finish an instruction give no item.
//  - Latency: the record appears on rsp_* the cycle after the byte that
//    completes the instruction is accepted.
//  - Throughput: one byte per cycle when not stalled. A byte is decoded in a
//    single pass through the step logic from decoder state to output register.
//  - Stall: req_stall rises only while a record sits in the output register
//    and the receiver holds rsp_stall; the held record stays put meanwhile.
//  - Reset (synchronous, active high): decoder back to expecting an opcode,
//    output register emptied.
//  - An 8-bit displacement is given zero-extended; sign-extend by mode.
// ============================================================================
module mov_instruction_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_instr_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_form,
   output logic        rsp_word_size,
   output logic        rsp_reg_is_dest,
   output logic [1:0]  rsp_mode,
   output logic [2:0]  rsp_reg_code,
   output logic [2:0]  rsp_rm_code,
   output logic [15:0] rsp_displacement,
   output logic [15:0] rsp_immediate,
   output logic [2:0]  rsp_length,
   output logic        rsp_bad_opcode
);

   // decoder state: phase counts bytes taken of the current instruction
   movdec_pkg::state_type state_ff, state_in;
   movdec_pkg::state_type step_nxt;
   logic                  step_emit;
   movdec_pkg::rec_type   step_rec;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   movdec_pkg::rec_type   rec_ff, rec_in;

   logic                  req_take;

   movdec_step u_step (
      .state_cur  (state_ff),
      .instr_byte (req_instr_byte),
      .state_nxt  (step_nxt),
      .emit       (step_emit),
      .rec        (step_rec)
   );

   // output slot free, or being emptied this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      state_in     = state_ff;
      rec_in       = rec_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (req_take) begin
         state_in = step_nxt;
         if (step_emit) begin
            rec_in       = step_rec;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_form         = rec_ff.form;
   assign rsp_word_size    = rec_ff.word_size;
   assign rsp_reg_is_dest  = rec_ff.reg_is_dest;
   assign rsp_mode         = rec_ff.mode;
   assign rsp_reg_code     = rec_ff.reg_code;
   assign rsp_rm_code      = rec_ff.rm_code;
   assign rsp_displacement = rec_ff.displacement;
   assign rsp_immediate    = rec_ff.immediate;
   assign rsp_length       = rec_ff.length;
   assign rsp_bad_opcode   = rec_ff.bad_opcode;

endmodule

// File: verif/tb.sv
// ============================================================================
// tb
// Self-checking bench for the MOV instruction decoder: a byte stream of
// directed and random instructions is fed in, and every decoded record is
// checked against a predictor that tracks the decoder state byte by byte.
// ============================================================================
module tb;

   // Opcode bytes of the five MOV forms
   localparam logic [7:0] OP_RM_REG_LO  = 8'h88;
   localparam logic [7:0] OP_RM_REG_HI  = 8'h8B;
   localparam logic [7:0] OP_IMM_RM_LO  = 8'hC6;
   localparam logic [7:0] OP_IMM_RM_HI  = 8'hC7;
   localparam logic [7:0] OP_IMM_REG_LO = 8'hB0;
   localparam logic [7:0] OP_IMM_REG_HI = 8'hBF;
   localparam logic [7:0] OP_MEM_ACC_LO = 8'hA0;
   localparam logic [7:0] OP_MEM_ACC_HI = 8'hA1;
   localparam logic [7:0] OP_ACC_MEM_LO = 8'hA2;
   localparam logic [7:0] OP_ACC_MEM_HI = 8'hA3;

   // Idle patterns
   localparam int IDLE_NONE = 0;
   localparam int IDLE_TX   = 1;
   localparam int IDLE_RX   = 2;
   localparam int IDLE_BOTH = 3;

   localparam int TIMEOUT_CYCLES = 200000;
   localparam int HOLD_CYCLES    = 150;
   localparam int DRAIN_CYCLES   = 6;

   // -------------------------------------------------------------------------
   // Predictor and store of expected records
   // -------------------------------------------------------------------------
   class mov_scoreboard;
      logic [2:0]            phase;
      movdec_pkg::form_type  form;
      logic [3:0]            opbits;
      logic [7:0]            modrm;
      logic [15:0]           disp;
      logic [15:0]           imm;
      movdec_pkg::rec_type   expected_q[$];
      int                    errors;
      int                    records;
      int                    rejects;

      function new();
         phase   = '0;
         form    = movdec_pkg::FORM_RM_REG;
         opbits  = '0;
         modrm   = '0;
         disp    = '0;
         imm     = '0;
         errors  = 0;
         records = 0;
         rejects = 0;
      endfunction

      function logic word_bit();
         return (form == movdec_pkg::FORM_IMM_REG) ? opbits[3] : opbits[0];
      endfunction

      function int modrm_bytes();
         return (form == movdec_pkg::FORM_RM_REG || form == movdec_pkg::FORM_IMM_RM) ? 1 : 0;
      endfunction

      function int disp_bytes();
         if (form == movdec_pkg::FORM_MEM_ACC || form == movdec_pkg::FORM_ACC_MEM) return 2;
         if (modrm_bytes() == 0) return 0;
         if (modrm[7:6] == movdec_pkg::MOD_DISP8) return 1;
         if (modrm[7:6] == movdec_pkg::MOD_DISP16) return 2;
         if (modrm[7:6] == movdec_pkg::MOD_NO_DISP && modrm[2:0] == movdec_pkg::RM_DIRECT)
            return 2;
         return 0;
      endfunction

      function void add_expected(movdec_pkg::rec_type r);
         expected_q.insert(expected_q.size(), r);
      endfunction

      // Advance the decoder by one accepted byte; queue a record if it ends
      // an instruction.
      function void note_input(logic [7:0] b);
         movdec_pkg::rec_type r;
         int                  off;
         int                  dl;
         int                  total;
         r = '0;
         if (phase == 0) begin
            modrm  = '0;
            disp   = '0;
            imm    = '0;
            opbits = b[3:0];
            if (b inside {[OP_RM_REG_LO:OP_RM_REG_HI]}) begin
               form = movdec_pkg::FORM_RM_REG;
            end else if (b inside {[OP_IMM_RM_LO:OP_IMM_RM_HI]}) begin
               form = movdec_pkg::FORM_IMM_RM;
            end else if (b inside {[OP_IMM_REG_LO:OP_IMM_REG_HI]}) begin
               form = movdec_pkg::FORM_IMM_REG;
            end else if (b inside {[OP_MEM_ACC_LO:OP_MEM_ACC_HI]}) begin
               form = movdec_pkg::FORM_MEM_ACC;
            end else if (b inside {[OP_ACC_MEM_LO:OP_ACC_MEM_HI]}) begin
               form = movdec_pkg::FORM_ACC_MEM;
            end else begin
               // not a MOV: error record at once, next byte is an opcode again
               form         = movdec_pkg::FORM_RM_REG;
               opbits       = '0;
               r.length     = movdec_pkg::LEN_SINGLE;
               r.bad_opcode = 1'b1;
               add_expected(r);
               rejects++;
               return;
            end
            phase = 3'd1;
            return;
         end

         if (modrm_bytes() == 1 && phase == 3'd1) begin
            modrm = b;
         end else begin
            off = int'(phase) - 1 - modrm_bytes();
            dl  = disp_bytes();
            if (off < dl) begin
               if (off == 0) disp[7:0] = b;
               else disp[15:8] = b;
            end else if (off - dl == 0) begin
               imm[7:0] = b;
            end else begin
               imm[15:8] = b;
            end
         end

         total = 1 + modrm_bytes() + disp_bytes();
         if (form == movdec_pkg::FORM_IMM_RM || form == movdec_pkg::FORM_IMM_REG)
            total += 1 + int'(word_bit());
         if (int'(phase) + 1 < total) begin
            phase = phase + 3'd1;
            return;
         end

         r.form         = form;
         r.word_size    = word_bit();
         r.displacement = disp;
         r.immediate    = imm;
         r.length       = 3'(total);
         case (form)
            movdec_pkg::FORM_RM_REG: begin
               r.reg_is_dest = opbits[1];
               r.mode        = modrm[7:6];
               r.reg_code    = modrm[5:3];
               r.rm_code     = modrm[2:0];
            end
            movdec_pkg::FORM_IMM_RM: begin
               // reg field of the ModRM byte plays no part here
               r.mode    = modrm[7:6];
               r.rm_code = modrm[2:0];
            end
            movdec_pkg::FORM_IMM_REG: begin
               r.reg_is_dest = 1'b1;
               r.mode        = movdec_pkg::MOD_REGISTER;
               r.reg_code    = opbits[2:0];
            end
            default: begin
               r.reg_is_dest = (form == movdec_pkg::FORM_MEM_ACC);
               r.rm_code     = movdec_pkg::RM_DIRECT;
            end
         endcase
         add_expected(r);
         phase = '0;
      endfunction

      function void check_field(string name, int e, int g);
         if (e != g) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
            errors++;
         end
      endfunction

      function void check_output(movdec_pkg::rec_type got);
         movdec_pkg::rec_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: record with none expected, got %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         records++;
         check_field("form", e.form, got.form);
         check_field("word_size", e.word_size, got.word_size);
         check_field("reg_is_dest", e.reg_is_dest, got.reg_is_dest);
         check_field("mode", e.mode, got.mode);
         check_field("reg_code", e.reg_code, got.reg_code);
         check_field("rm_code", e.rm_code, got.rm_code);
         check_field("displacement", e.displacement, got.displacement);
         check_field("immediate", e.immediate, got.immediate);
         check_field("length", e.length, got.length);
         check_field("bad_opcode", e.bad_opcode, got.bad_opcode);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, DUT
   // -------------------------------------------------------------------------
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_instr_byte = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_form;
   logic                rsp_word_size;
   logic                rsp_reg_is_dest;
   logic [1:0]          rsp_mode;
   logic [2:0]          rsp_reg_code;
   logic [2:0]          rsp_rm_code;
   logic [15:0]         rsp_displacement;
   logic [15:0]         rsp_immediate;
   logic [2:0]          rsp_length;
   logic                rsp_bad_opcode;
   movdec_pkg::rec_type rsp_rec;

   mov_scoreboard sb = new;

   int         idle_mode = IDLE_NONE;
   bit         hold_go   = 1'b0;   // raised once by the stimulus to ask for the hold-off
   bit         hold_done = 1'b0;
   int         hold_left = 0;
   int         bytes_fed = 0;
   logic [7:0] stim_q[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   mov_instruction_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_instr_byte   (req_instr_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_form         (rsp_form),
      .rsp_word_size    (rsp_word_size),
      .rsp_reg_is_dest  (rsp_reg_is_dest),
      .rsp_mode         (rsp_mode),
      .rsp_reg_code     (rsp_reg_code),
      .rsp_rm_code      (rsp_rm_code),
      .rsp_displacement (rsp_displacement),
      .rsp_immediate    (rsp_immediate),
      .rsp_length       (rsp_length),
      .rsp_bad_opcode   (rsp_bad_opcode)
   );

   // Result ports packed in record order
   assign rsp_rec = {rsp_form, rsp_word_size, rsp_reg_is_dest, rsp_mode, rsp_reg_code,
                     rsp_rm_code, rsp_displacement, rsp_immediate, rsp_length,
                     rsp_bad_opcode};

   // -------------------------------------------------------------------------
   // Receiver: random stall by idle pattern, plus one long hold-off counted
   // here so the decoder's output fills and it pushes back on the input.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_go && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (idle_mode == IDLE_RX) begin
            rsp_stall <= ($urandom_range(99) < 46);
         end else if (idle_mode == IDLE_BOTH) begin
            rsp_stall <= ($urandom_range(99) < 9);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Checker: sample accepted records on the edge (pre-edge values)
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_output(rsp_rec);
   end

   // -------------------------------------------------------------------------
   // Sender
   // -------------------------------------------------------------------------
   // Offer one byte; idle cycles go in front of it by the current pattern.
   // Returns at the edge where it is taken, leaving valid high so a
   // back-to-back item needs no second assignment in that step.
   task automatic send_byte(input logic [7:0] b);
      int pct;
      pct = (idle_mode == IDLE_TX) ? 46 : (idle_mode == IDLE_BOTH) ? 9 : 0;
      while ($urandom_range(99) < pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_instr_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_input(b);
      bytes_fed++;
   endtask

   task automatic drain_stim();
      while (stim_q.size() != 0) send_byte(stim_q.pop_front());
   endtask

   function automatic void stim_add(input logic [7:0] b);
      stim_q.insert(stim_q.size(), b);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255));
   endfunction

   // Queue one instruction: mostly well-formed MOVs with random content,
   // some rejected opcodes and some raw noise that may land mid-instruction.
   task automatic push_instr();
      int         kind;
      int         dl;
      int         il;
      logic [7:0] op;
      logic [1:0] md;
      logic [2:0] rm;
      kind = $urandom_range(99);
      dl   = 0;
      il   = 0;
      if (kind < 85) begin
         md = 2'($urandom_range(3));
         rm = ($urandom_range(3) == 0) ? movdec_pkg::RM_DIRECT : 3'($urandom_range(7));
         case ($urandom_range(4))
            0: op = OP_RM_REG_LO + 8'($urandom_range(3));
            1: op = OP_IMM_RM_LO + 8'($urandom_range(1));
            2: op = OP_IMM_REG_LO + 8'($urandom_range(15));
            3: op = OP_MEM_ACC_LO + 8'($urandom_range(1));
            default: op = OP_ACC_MEM_LO + 8'($urandom_range(1));
         endcase
         stim_add(op);
         if (op inside {[OP_RM_REG_LO:OP_RM_REG_HI], [OP_IMM_RM_LO:OP_IMM_RM_HI]}) begin
            stim_add({md, 3'($urandom_range(7)), rm});
            if (md == movdec_pkg::MOD_DISP8) begin
               dl = 1;
            end else if (md == movdec_pkg::MOD_DISP16 ||
                         (md == movdec_pkg::MOD_NO_DISP && rm == movdec_pkg::RM_DIRECT)) begin
               dl = 2;
            end
            if (op inside {[OP_IMM_RM_LO:OP_IMM_RM_HI]}) il = 1 + op[0];
         end else if (op inside {[OP_IMM_REG_LO:OP_IMM_REG_HI]}) begin
            il = 1 + op[3];
         end else begin
            dl = 2;
         end
         repeat (dl + il) stim_add(rand_byte());
      end else if (kind < 95) begin
         do op = rand_byte();
         while (op inside {[OP_RM_REG_LO:OP_RM_REG_HI], [OP_IMM_RM_LO:OP_IMM_RM_HI],
                           [OP_IMM_REG_LO:OP_IMM_REG_HI], [OP_MEM_ACC_LO:OP_ACC_MEM_HI]});
         stim_add(op);
      end else begin
         repeat ($urandom_range(4, 1)) stim_add(rand_byte());
      end
   endtask

   task automatic run_stream(input int n_bytes);
      int start;
      start = bytes_fed;
      while (bytes_fed - start < n_bytes) begin
         push_instr();
         drain_stim();
      end
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: each form, register and memory modes, direct address in
      // both ModRM forms, the longest instruction, field extremes, and
      // non-MOV opcodes at both ends of the byte range.
      stim_q = '{8'h88, 8'hC0,                           // rm/reg, register mode
                 8'h8B, 8'h06, 8'h34, 8'h12,             // direct address, d=1 w=1
                 8'h89, 8'h7F, 8'h80,                    // 8-bit displacement
                 8'hC7, 8'h06, 8'hFF, 8'hFF, 8'hFF, 8'hFF, // imm to direct address
                 8'hC6, 8'hF8, 8'h5A,                    // imm to rm, reg field ignored
                 8'hBF, 8'hFF, 8'hFF,                    // imm to reg, word
                 8'hA0, 8'hFF, 8'hFF,                    // mem to acc
                 8'hA3, 8'h00, 8'h00,                    // acc to mem
                 8'h00, 8'hFF};                          // rejected opcodes
      drain_stim();

      // Long output hold-off with the sender running flat out
      hold_go = 1'b1;
      run_stream(80);

      // Random stream under each idle pattern
      for (int m = IDLE_NONE; m <= IDLE_BOTH; m++) begin
         idle_mode = m;
         run_stream(330);
      end
      req_valid <= 1'b0;
      idle_mode = IDLE_NONE;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Fed %0d bytes; checked %0d records, %0d of them rejected opcodes,",
               bytes_fed, sb.records, sb.rejects);
      $display("over all five forms, four idle patterns and one long output hold-off.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_CYCLES * 8);
      $display("tb failed");
      $finish;
   end

endmodule
